// File: hdl/motor_speed_angle_torque_ctrl_top_assert.svh
// Assertion macros used by the controller's checker.
`ifndef MOTOR_SPEED_ANGLE_TORQUE_CTRL_TOP_ASSERT_SVH
`define MOTOR_SPEED_ANGLE_TORQUE_CTRL_TOP_ASSERT_SVH
// Clocked property, disabled while reset is high.
`define MSATC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that also holds across reset.
`define MSATC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/msatc_pkg.sv
// Shared types, constants and helpers of the motor controller.
package msatc_pkg;
   localparam int OPND_W   = 64;
   localparam int MUL_BITS = 20;
   localparam int DSR_W    = 20;
   localparam int DIV_BITS = 64;
   localparam int DT_W     = 20;
   localparam int RSP_W    = 48;

   localparam logic [DSR_W-1:0] US_PER_S   = 20'd1000000;
   localparam logic [DSR_W-1:0] FILTER_DIV = 20'd10;

   localparam logic signed [63:0] SPD_MAX = 64'sd8388607;
   localparam logic signed [63:0] SPD_MIN = -64'sd8388608;
   localparam logic signed [63:0] INC_LIM = 64'sd655360;
   localparam logic signed [63:0] D_LIM   = 64'sd1073741824;
   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
   localparam logic [63:0] ANGLE_LO = 64'd50;
   localparam logic [63:0] ANGLE_HI = 64'd100;

   localparam logic [1:0] MODE_SPEED  = 2'd0;
   localparam logic [1:0] MODE_ANGLE  = 2'd1;
   localparam logic [1:0] MODE_TORQUE = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic ITEM_CONTROL = 1'b0;
   localparam logic ITEM_TICK    = 1'b1;

   typedef enum logic [2:0] {
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_TARGET_SPEED,
      REG_TARGET_ANGLE, REG_TARGET_TORQUE, REG_ANGLE_TOL, REG_START_MODE
   } reg_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sat_range(logic signed [63:0] v,
                                                    logic signed [63:0] lo,
                                                    logic signed [63:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction
endpackage

// File: hdl/msatc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module msatc_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msatc_pkg::OPND_W-1:0]  opnd_a,
   input  logic [msatc_pkg::MUL_BITS-1:0] opnd_b,
   output logic [msatc_pkg::OPND_W-1:0]  product,
   output msatc_pkg::unit_status_type    status
);
   import msatc_pkg::*;

   localparam int CNT_W = $clog2(MUL_BITS);

   logic [OPND_W-1:0]   acc_ff, a_sh_ff;
   logic [MUL_BITS-1:0] b_sh_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff  <= '0;
            a_sh_ff <= opnd_a;
            b_sh_ff <= opnd_b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (b_sh_ff[0]) begin
               acc_ff <= acc_ff + a_sh_ff;
            end
            a_sh_ff <= a_sh_ff << 1;
            b_sh_ff <= b_sh_ff >> 1;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

// File: hdl/msatc_div.sv
// Restoring divider, one quotient bit per cycle.
module msatc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [msatc_pkg::OPND_W-1:0] dividend,
   input  logic [msatc_pkg::DSR_W-1:0]  divisor,
   output logic [msatc_pkg::OPND_W-1:0] quotient,
   output msatc_pkg::unit_status_type   status
);
   import msatc_pkg::*;

   localparam int CNT_W = $clog2(DIV_BITS);

   logic [OPND_W-1:0] dvd_ff;
   logic [DSR_W-1:0]  dsr_ff, rem_ff, rem_in;
   logic [DSR_W:0]    rem_sh, rem_sub;
   logic              q_bit;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[OPND_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      q_bit   = (rem_sh >= {1'b0, dsr_ff});
      rem_in  = q_bit ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[OPND_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

// File: hdl/motor_speed_angle_torque_ctrl_top.sv
// Top level of the motor speed, angle and torque controller.
//
//  channel | direction | transfer contents
//  req_    | in        | tuser: item kind; tdata: encoder_count, elapsed_us
//  rsp_    | out       | tdata: pwm_forward, pwm_reverse, speed_now, mode_now,
//          |           |        interval_error
//  csr_    | in        | write enable, register index, write data
//
// One item at a time passes through a sequencer that shares one bit-serial
// multiplier and one restoring divider. A speed tick runs a multiply and two
// divides, a PID step two multiply-divide pairs and three gain multiplies;
// a zero interval skips a tick's unit work and the PID pairs, a zero target
// all PID work. A result waits in the output register while the next item
// is taken; a stalled rsp_ holds the sequencer only at its last step. Reset
// is synchronous; it sets sequencer, configuration and history to defaults.
module motor_speed_angle_torque_ctrl_top #(
   parameter int PWM_MAX     = 255,
   parameter int PWM_MIN     = 30,
   parameter int COUNT_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser,   // item kind
   // encoder_count [COUNT_WIDTH-1:0], elapsed_us, zero fill
   input  logic [((COUNT_WIDTH+msatc_pkg::DT_W+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pwm_forward, pwm_reverse, speed_now, mode_now, interval_error, zero fill
   output logic [msatc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import msatc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_TK_MUL, ST_TK_DIV, ST_TK_FLT,
      ST_SP_MUL1, ST_SP_DIV1, ST_SP_MUL2, ST_SP_DIV2, ST_SP_ACC,
      ST_SP_MP, ST_SP_MI, ST_SP_MD, ST_SP_OUT, ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0]        gain_p_ff, gain_i_ff, gain_d_ff, angle_tol_ff;
   logic signed [23:0] target_speed_ff, target_angle_ff;
   logic signed [8:0]  target_torque_ff;

   // controller state
   logic signed [COUNT_WIDTH-1:0] prev_count_ff, count_ff;
   logic signed [23:0] speed_est_ff, prev_err_ff, err_ff;
   logic [DT_W-1:0]    last_int_ff, dt_ff;
   logic signed [31:0] integral_ff, d_ff;
   logic signed [20:0] inc_ff;
   logic signed [65:0] sum_ff;
   logic [1:0]         active_mode_ff;
   logic [7:0]         drive_fwd_ff, drive_rev_ff;
   logic               kind_ff, flag_ff, sign_ff;

   // arithmetic unit requests
   logic              mul_start_ff, div_start_ff;
   logic [OPND_W-1:0] mul_a_ff, div_dvd_ff, mul_prod, div_q;
   logic [MUL_BITS-1:0] mul_b_ff;
   logic [DSR_W-1:0]  div_dsr_ff;
   unit_status_type   mul_status, div_status;

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // combinational helpers
   logic signed [63:0] delta, div_q_s, se64, filt_num, filt_sat, err_full, err_sat64;
   logic signed [63:0] ediff, inc_sat, d_sat, integ_next, aerr, tq64;
   logic signed [65:0] prod66, psig, out_full;
   logic [63:0]        amag, ahalf, aval, tmag;
   logic [47:0]        out_mag;
   logic signed [23:0] err_sat;

   function automatic logic [7:0] clamp_duty(logic [47:0] m, logic [47:0] lo,
                                             logic [47:0] hi);
      logic [47:0] sel;
      sel = (m < lo) ? lo : ((m > hi) ? hi : m);
      return sel[7:0];
   endfunction

   msatc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .opnd_a  (mul_a_ff),
      .opnd_b  (mul_b_ff),
      .product (mul_prod),
      .status  (mul_status)
   );

   msatc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dsr_ff),
      .quotient (div_q),
      .status   (div_status)
   );

   always_comb begin
      delta      = 64'(count_ff) - 64'(prev_count_ff);
      div_q_s    = sign_ff ? -$signed(div_q) : $signed(div_q);
      se64       = 64'(speed_est_ff);
      filt_num   = div_q_s + (se64 <<< 3) + se64;   // raw + 9*old
      filt_sat   = sat_range(div_q_s, SPD_MIN, SPD_MAX);
      err_full   = 64'(target_speed_ff) - se64;
      err_sat64  = sat_range(err_full, SPD_MIN, SPD_MAX);
      err_sat    = err_sat64[23:0];
      ediff      = 64'(err_ff) - 64'(prev_err_ff);
      inc_sat    = sat_range(div_q_s, -INC_LIM, INC_LIM);
      d_sat      = sat_range(div_q_s, -D_LIM, D_LIM);
      integ_next = sat_range(64'(integral_ff) + 64'(inc_ff), I32_MIN, I32_MAX);
      prod66     = $signed({2'b00, mul_prod});
      psig       = sign_ff ? -prod66 : prod66;
      // truncate toward zero on the final scale by 2^24
      out_full   = sum_ff[65] ? ((sum_ff + 66'sd16777215) >>> 24) : (sum_ff >>> 24);
      out_mag    = out_full[65] ? 48'(-out_full) : 48'(out_full);
      aerr       = 64'(target_angle_ff) - 64'(count_ff);
      amag       = mag64(aerr);
      ahalf      = amag >> 1;
      aval       = (ahalf < ANGLE_LO) ? ANGLE_LO : ((ahalf > ANGLE_HI) ? ANGLE_HI : ahalf);
      tq64       = 64'(target_torque_ff);
      tmag       = mag64(tq64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         gain_p_ff        <= 16'd256;
         gain_i_ff        <= '0;
         gain_d_ff        <= '0;
         target_speed_ff  <= '0;
         target_angle_ff  <= '0;
         target_torque_ff <= '0;
         angle_tol_ff     <= 16'd4;
         prev_count_ff    <= '0;
         speed_est_ff     <= '0;
         last_int_ff      <= '0;
         integral_ff      <= '0;
         prev_err_ff      <= '0;
         active_mode_ff   <= MODE_SPEED;
         drive_fwd_ff     <= '0;
         drive_rev_ff     <= '0;
         mul_start_ff     <= 1'b0;
         div_start_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         // drop the result once taken; the last step reloads it itself
         if (rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= req_tuser;
                  count_ff <= req_tdata[COUNT_WIDTH-1:0];
                  dt_ff    <= req_tdata[COUNT_WIDTH+DT_W-1:COUNT_WIDTH];
                  flag_ff  <= 1'b0;
                  state_ff <= ST_DECODE;
               end
               if (csr_wen) begin
                  case (reg_index_type'(csr_index))
                     REG_GAIN_P:        gain_p_ff        <= csr_wdata[15:0];
                     REG_GAIN_I:        gain_i_ff        <= csr_wdata[15:0];
                     REG_GAIN_D:        gain_d_ff        <= csr_wdata[15:0];
                     REG_TARGET_SPEED:  target_speed_ff  <= csr_wdata;
                     REG_TARGET_ANGLE:  target_angle_ff  <= csr_wdata;
                     REG_TARGET_TORQUE: target_torque_ff <= csr_wdata[8:0];
                     REG_ANGLE_TOL:     angle_tol_ff     <= csr_wdata[15:0];
                     REG_START_MODE: begin
                        if (csr_wdata[1:0] != MODE_NONE) begin
                           active_mode_ff <= csr_wdata[1:0];
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_DECODE: begin
               if (kind_ff == ITEM_TICK) begin
                  last_int_ff <= dt_ff;
                  if (dt_ff == '0) begin
                     flag_ff  <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else begin
                     sign_ff      <= delta[63];
                     mul_a_ff     <= mag64(delta);
                     mul_b_ff     <= US_PER_S;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_TK_MUL;
                  end
               end else begin
                  case (active_mode_ff)
                     MODE_TORQUE: begin
                        if (tq64 == 0) begin
                           drive_fwd_ff <= '0;
                           drive_rev_ff <= '0;
                        end else if (tq64 > 0) begin
                           drive_fwd_ff <= clamp_duty(tmag[47:0], 48'(PWM_MIN), 48'(PWM_MAX));
                           drive_rev_ff <= '0;
                        end else begin
                           drive_fwd_ff <= '0;
                           drive_rev_ff <= clamp_duty(tmag[47:0], 48'(PWM_MIN), 48'(PWM_MAX));
                        end
                        state_ff <= ST_FINISH;
                     end
                     MODE_ANGLE: begin
                        if (amag < 64'(angle_tol_ff)) begin
                           drive_fwd_ff   <= '0;
                           drive_rev_ff   <= '0;
                           active_mode_ff <= MODE_TORQUE;
                        end else if (aerr > 0) begin
                           drive_fwd_ff <= aval[7:0];
                           drive_rev_ff <= '0;
                        end else if (aerr < 0) begin
                           drive_fwd_ff <= '0;
                           drive_rev_ff <= aval[7:0];
                        end
                        state_ff <= ST_FINISH;
                     end
                     default: begin
                        if (target_speed_ff == '0) begin
                           drive_fwd_ff <= '0;
                           drive_rev_ff <= '0;
                           state_ff     <= ST_FINISH;
                        end else begin
                           err_ff <= err_sat;
                           if (last_int_ff == '0) begin
                              flag_ff  <= 1'b1;
                              inc_ff   <= '0;
                              d_ff     <= '0;
                              state_ff <= ST_SP_ACC;
                           end else begin
                              sign_ff      <= err_sat64[63];
                              mul_a_ff     <= mag64(err_sat64);
                              mul_b_ff     <= last_int_ff;
                              mul_start_ff <= 1'b1;
                              state_ff     <= ST_SP_MUL1;
                           end
                        end
                     end
                  endcase
               end
            end
            ST_TK_MUL: begin
               if (mul_status.done) begin
                  div_dvd_ff   <= mul_prod;
                  div_dsr_ff   <= dt_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_TK_DIV;
               end
            end
            ST_TK_DIV: begin
               if (div_status.done) begin
                  sign_ff      <= filt_num[63];
                  div_dvd_ff   <= mag64(filt_num);
                  div_dsr_ff   <= FILTER_DIV;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_TK_FLT;
               end
            end
            ST_TK_FLT: begin
               if (div_status.done) begin
                  speed_est_ff  <= filt_sat[23:0];
                  prev_count_ff <= count_ff;
                  state_ff      <= ST_FINISH;
               end
            end
            ST_SP_MUL1: begin
               if (mul_status.done) begin
                  div_dvd_ff   <= mul_prod << 16;
                  div_dsr_ff   <= US_PER_S;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_SP_DIV1;
               end
            end
            ST_SP_DIV1: begin
               if (div_status.done) begin
                  inc_ff       <= inc_sat[20:0];
                  sign_ff      <= ediff[63];
                  mul_a_ff     <= mag64(ediff);
                  mul_b_ff     <= US_PER_S;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SP_MUL2;
               end
            end
            ST_SP_MUL2: begin
               if (mul_status.done) begin
                  div_dvd_ff   <= mul_prod;
                  div_dsr_ff   <= last_int_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_SP_DIV2;
               end
            end
            ST_SP_DIV2: begin
               if (div_status.done) begin
                  d_ff     <= d_sat[31:0];
                  state_ff <= ST_SP_ACC;
               end
            end
            ST_SP_ACC: begin
               integral_ff  <= integ_next[31:0];
               prev_err_ff  <= err_ff;
               sum_ff       <= '0;
               sign_ff      <= err_ff[23];
               mul_a_ff     <= mag64(64'(err_ff));
               mul_b_ff     <= MUL_BITS'(gain_p_ff);
               mul_start_ff <= 1'b1;
               state_ff     <= ST_SP_MP;
            end
            ST_SP_MP: begin
               if (mul_status.done) begin
                  sum_ff       <= sum_ff + (psig <<< 16);
                  sign_ff      <= integral_ff[31];
                  mul_a_ff     <= mag64(64'(integral_ff));
                  mul_b_ff     <= MUL_BITS'(gain_i_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SP_MI;
               end
            end
            ST_SP_MI: begin
               if (mul_status.done) begin
                  sum_ff       <= sum_ff + psig;
                  sign_ff      <= d_ff[31];
                  mul_a_ff     <= mag64(64'(d_ff));
                  mul_b_ff     <= MUL_BITS'(gain_d_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SP_MD;
               end
            end
            ST_SP_MD: begin
               if (mul_status.done) begin
                  sum_ff   <= sum_ff + (psig <<< 16);
                  state_ff <= ST_SP_OUT;
               end
            end
            ST_SP_OUT: begin
               // zero output holds the previous duties
               if (out_full > 0) begin
                  drive_fwd_ff <= clamp_duty(out_mag, 48'(PWM_MIN), 48'(PWM_MAX));
                  drive_rev_ff <= '0;
               end else if (out_full < 0) begin
                  drive_fwd_ff <= '0;
                  drive_rev_ff <= clamp_duty(out_mag, 48'(PWM_MIN), 48'(PWM_MAX));
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {5'b0, flag_ff, active_mode_ff, speed_est_ff,
                                   drive_rev_ff, drive_fwd_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// File: hdl/msatc_checker.sv
// Port-level checker for the motor controller, bound to the top level.
module msatc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [msatc_pkg::RSP_W-1:0] rsp_tdata
);
`include "motor_speed_angle_torque_ctrl_top_assert.svh"

   `MSATC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `MSATC_ASSERT(a_mode_code, clock, reset, rsp_tvalid |-> rsp_tdata[41:40] != 2'd3, "reserved mode reported")
   `MSATC_ASSERT(a_one_side, clock, reset, rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0 || rsp_tdata[15:8] == 8'd0), "both bridge sides driven")
   `MSATC_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result valid after reset")
endmodule

bind motor_speed_angle_torque_ctrl_top msatc_checker u_msatc_checker (.*);
